// File: hw/rtl/differential_drive_odometry_assert.svh
// ----------------------------------------------------------------------------
// differential drive odometry assertion macros
// concurrent assertion shorthands used by the checker file ddo_checker
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH

// condition holds in the same cycle as the antecedent
`define DDO_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("odometry assertion failed");

// condition holds in the cycle after the antecedent
`define DDO_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("odometry assertion failed");

`endif

// File: hw/rtl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// types, codes and constants of the differential drive odometry block
// ----------------------------------------------------------------------------
package ddo_pkg;

  // input word
  typedef struct packed {
    logic               cmd;
    logic signed [31:0] left_position;
    logic signed [31:0] right_position;
    logic [63:0]        sample_time;
  } in_word_t;

  // result word
  typedef struct packed {
    logic               updated;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] speed;
    logic signed [31:0] turn_rate;
  } out_word_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_METRES_PER_TICK      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_PER_METRE_DIFF = 1'b1;

  // datapath widths
  localparam int ACC_W  = 128;
  localparam int MUL_W  = 34;
  localparam int DT_W   = 64;
  localparam int CORD_W = 34;

  localparam logic [31:0]      CORDIC_GAIN  = 32'd652032874;
  localparam logic [MUL_W-1:0] USEC_PER_SEC = 34'd1000000;

  // arctangent of 2^-i in binary-angle units
  localparam logic [31:0] ATAN_TAB [0:31] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_ML, OP_MR, OP_HD, OP_COR, OP_PX, OP_PY,
    OP_SM1, OP_SM2, OP_SDV, OP_TM1, OP_TM2, OP_TM3, OP_TDV, OP_OUT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic start;
  } dp_cmd_t;

  typedef struct packed {
    logic is_update;
    logic done;
  } dp_stat_t;

endpackage

// File: hw/rtl/ddo_mul.sv
// ----------------------------------------------------------------------------
// ddo_mul
// shift-add multiplier, one multiplier bit per cycle, signed multiplier
// ----------------------------------------------------------------------------
module ddo_mul import ddo_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ACC_W-1:0] mcand_i,
  input  logic [MUL_W-1:0] mplier_i,
  output logic             done_o,
  output logic [ACC_W-1:0] prod_o
);

  localparam int CNT_W = $clog2(MUL_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(MUL_W - 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [ACC_W-1:0] acc_q, mc_q, term, sum;
  logic [MUL_W-1:0] mp_q;
  logic             top;

  // top multiplier bit carries negative weight
  always_comb begin
    top  = (cnt_q == LAST);
    term = mc_q ^ {ACC_W{top}};
    sum  = acc_q + term + {{(ACC_W-1){1'b0}}, top};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (top) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // accumulator and operand shifters
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      mc_q  <= mcand_i;
      mp_q  <= mplier_i;
    end else if (busy_q) begin
      if (mp_q[0]) begin
        acc_q <= sum;
      end
      mc_q <= {mc_q[ACC_W-2:0], 1'b0};
      mp_q <= {1'b0, mp_q[MUL_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// File: hw/rtl/ddo_div.sv
// ----------------------------------------------------------------------------
// ddo_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ddo_div import ddo_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ACC_W-1:0] dividend_i,
  input  logic [DT_W-1:0]  divisor_i,
  output logic             done_o,
  output logic [ACC_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(ACC_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(ACC_W - 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [ACC_W-1:0] quo_q;
  logic [DT_W-1:0]  rem_q, dvs_q, rem_next;
  logic [DT_W:0]    rx, diff;
  logic             ge;

  // trial subtract
  always_comb begin
    rx       = {rem_q, quo_q[ACC_W-1]};
    diff     = rx - {1'b0, dvs_q};
    ge       = (rx >= {1'b0, dvs_q});
    rem_next = ge ? diff[DT_W-1:0] : rx[DT_W-1:0];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == LAST) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // dividend shifts out while quotient shifts in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[ACC_W-2:0], ge};
      rem_q <= rem_next;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// File: hw/rtl/ddo_dp.sv
// ----------------------------------------------------------------------------
// ddo_dp
// odometry datapath: pose state, multiplier, divider, cordic, result word
// ----------------------------------------------------------------------------
module ddo_dp import ddo_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  input  in_word_t             in_data_i,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o,
  output out_word_t            out_data_o
);

  localparam int NSTEP  = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int STEP_W = $clog2(NSTEP);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NSTEP - 1);

  // configuration and pose state
  logic [31:0] mpt_q, apmd_q;
  logic        primed_q;
  logic [31:0] last_l_q, last_r_q, px_q, py_q, hd_q;
  logic [63:0] last_t_q;

  // working registers
  logic [31:0]      dl_q, dr_q, spd_q, trn_q;
  logic [DT_W-1:0]  dt_q;
  logic [47:0]      ml_q, mr_q;
  logic [ACC_W-1:0] rp_q;
  logic             upd_q;
  out_word_t        out_q;

  logic             is_update, load;
  logic [48:0]      dml, sml;
  logic [47:0]      travel;
  logic [32:0]      ts, tt, mag_s, mag_t;
  logic             neg_s, neg_t;
  logic [ACC_W-1:0] mcand, prod, quot;
  logic [MUL_W-1:0] mplier;
  logic             mul_start, mul_done, div_start, div_done;

  // cordic registers
  logic                     cor_busy_q, cor_done_q, flip_q;
  logic [STEP_W-1:0]        cor_i_q;
  logic signed [CORD_W-1:0] cx_q, cy_q, cz_q, c_q, s_q;
  logic signed [CORD_W-1:0] sx, sy, at, nx, ny, nz;
  logic [4:0]               idx;
  logic [31:0]              ang;
  logic                     cor_flip;

  function automatic logic [31:0] sat_rate(logic over_hi, logic [31:0] v, logic neg);
    logic [31:0] limit, m;
    limit = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    m     = (over_hi || (v > limit)) ? limit : v;
    return neg ? (32'd0 - m) : m;
  endfunction

  // item classification and derived operands
  always_comb begin
    is_update = !in_data_i.cmd && primed_q && (in_data_i.sample_time != last_t_q);
    load      = cmd_i.start && (cmd_i.op == OP_LOAD);
    dml       = {ml_q[47], ml_q} - {mr_q[47], mr_q};
    sml       = {ml_q[47], ml_q} + {mr_q[47], mr_q};
    travel    = sml[48:1];
    ts        = {dl_q[31], dl_q} + {dr_q[31], dr_q};
    tt        = {dl_q[31], dl_q} - {dr_q[31], dr_q};
    neg_s     = ts[32];
    neg_t     = tt[32];
    mag_s     = neg_s ? (33'd0 - ts) : ts;
    mag_t     = neg_t ? (33'd0 - tt) : tt;
  end

  // multiplier operand select
  always_comb begin
    mcand  = '0;
    mplier = '0;
    unique case (cmd_i.op)
      OP_ML:  begin mcand = {{96{dl_q[31]}}, dl_q};   mplier = {2'b00, mpt_q};  end
      OP_MR:  begin mcand = {{96{dr_q[31]}}, dr_q};   mplier = {2'b00, mpt_q};  end
      OP_HD:  begin mcand = {{79{dml[48]}}, dml};     mplier = {2'b00, apmd_q}; end
      OP_PX:  begin mcand = {{80{travel[47]}}, travel}; mplier = c_q;          end
      OP_PY:  begin mcand = {{80{travel[47]}}, travel}; mplier = s_q;          end
      OP_SM1: begin mcand = {95'd0, mag_s};           mplier = {2'b00, mpt_q};  end
      OP_TM1: begin mcand = {95'd0, mag_t};           mplier = {2'b00, mpt_q};  end
      OP_TM2: begin mcand = rp_q;                     mplier = {2'b00, apmd_q}; end
      OP_SM2, OP_TM3: begin mcand = rp_q;             mplier = USEC_PER_SEC;    end
      default: begin mcand = '0;                      mplier = '0;              end
    endcase
  end

  assign mul_start = cmd_i.start && (cmd_i.op == OP_ML || cmd_i.op == OP_MR ||
                     cmd_i.op == OP_HD || cmd_i.op == OP_PX || cmd_i.op == OP_PY ||
                     cmd_i.op == OP_SM1 || cmd_i.op == OP_SM2 || cmd_i.op == OP_TM1 ||
                     cmd_i.op == OP_TM2 || cmd_i.op == OP_TM3);
  assign div_start = cmd_i.start && (cmd_i.op == OP_SDV || cmd_i.op == OP_TDV);

  ddo_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mcand),
    .mplier_i (mplier),
    .done_o   (mul_done),
    .prod_o   (prod)
  );

  ddo_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rp_q),
    .divisor_i  (dt_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpt_q  <= '0;
      apmd_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_METRES_PER_TICK:      mpt_q  <= cfg_wdata_i;
        REG_ANGLE_PER_METRE_DIFF: apmd_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pose state: load of a new word and pose writeback
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
      last_l_q <= '0;
      last_r_q <= '0;
      last_t_q <= '0;
      px_q     <= '0;
      py_q     <= '0;
      hd_q     <= '0;
    end else if (load) begin
      if (in_data_i.cmd) begin
        px_q <= '0;
        py_q <= '0;
        hd_q <= '0;
      end else if (!primed_q || is_update) begin
        primed_q <= 1'b1;
        last_l_q <= in_data_i.left_position;
        last_r_q <= in_data_i.right_position;
        last_t_q <= in_data_i.sample_time;
      end
    end else if (mul_done) begin
      unique case (cmd_i.op)
        OP_HD:   hd_q <= hd_q + prod[63:32];
        OP_PX:   px_q <= px_q + prod[61:30];
        OP_PY:   py_q <= py_q + prod[61:30];
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (load) begin
      dl_q  <= in_data_i.left_position - last_l_q;
      dr_q  <= in_data_i.right_position - last_r_q;
      dt_q  <= in_data_i.sample_time - last_t_q;
      upd_q <= is_update;
      spd_q <= '0;
      trn_q <= '0;
    end else if (mul_done) begin
      unique case (cmd_i.op)
        OP_ML:   ml_q <= prod[63:16];
        OP_MR:   mr_q <= prod[63:16];
        OP_SM1, OP_SM2, OP_TM1, OP_TM2, OP_TM3: rp_q <= prod;
        default: ;
      endcase
    end else if (div_done) begin
      if (cmd_i.op == OP_SDV) begin
        spd_q <= sat_rate(|quot[127:49], quot[48:17], neg_s);
      end else begin
        trn_q <= sat_rate(|quot[127:96], quot[95:64], neg_t);
      end
    end
  end

  // cordic step
  always_comb begin
    idx      = 5'(cor_i_q);
    at       = {2'b00, ATAN_TAB[idx]};
    sx       = cx_q >>> idx;
    sy       = cy_q >>> idx;
    cor_flip = hd_q[31] ^ hd_q[30];
    ang      = cor_flip ? {~hd_q[31], hd_q[30:0]} : hd_q;
    if (!cz_q[CORD_W-1]) begin
      nx = cx_q - sy;
      ny = cy_q + sx;
      nz = cz_q - at;
    end else begin
      nx = cx_q + sy;
      ny = cy_q - sx;
      nz = cz_q + at;
    end
  end

  // cordic control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cor_busy_q <= 1'b0;
      cor_done_q <= 1'b0;
      cor_i_q    <= '0;
    end else if (cmd_i.start && cmd_i.op == OP_COR) begin
      cor_busy_q <= 1'b1;
      cor_done_q <= 1'b0;
      cor_i_q    <= '0;
    end else if (cor_busy_q) begin
      cor_i_q <= cor_i_q + STEP_W'(1);
      if (cor_i_q == STEP_LAST) begin
        cor_busy_q <= 1'b0;
        cor_done_q <= 1'b1;
      end
    end else begin
      cor_done_q <= 1'b0;
    end
  end

  // cordic vector, unfolded at the last step
  always_ff @(posedge clk_i) begin
    if (cmd_i.start && cmd_i.op == OP_COR) begin
      flip_q <= cor_flip;
      cx_q   <= {2'b00, CORDIC_GAIN};
      cy_q   <= '0;
      cz_q   <= {{2{ang[31]}}, ang};
    end else if (cor_busy_q) begin
      cx_q <= nx;
      cy_q <= ny;
      cz_q <= nz;
      if (cor_i_q == STEP_LAST) begin
        c_q <= flip_q ? -nx : nx;
        s_q <= flip_q ? -ny : ny;
      end
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.start && cmd_i.op == OP_OUT) begin
      out_q.updated   <= upd_q;
      out_q.pos_x     <= px_q;
      out_q.pos_y     <= py_q;
      out_q.heading   <= hd_q;
      out_q.speed     <= spd_q;
      out_q.turn_rate <= trn_q;
    end
  end

  assign stat_o.is_update = is_update;
  assign stat_o.done      = mul_done | div_done | cor_done_q;
  assign out_data_o       = out_q;

endmodule

// File: hw/rtl/ddo_ctrl.sv
// ----------------------------------------------------------------------------
// ddo_ctrl
// sequencer: steps the datapath through one word and owns the handshakes
// ----------------------------------------------------------------------------
module ddo_ctrl import ddo_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ML   = 4'd1;
  localparam logic [3:0] S_MR   = 4'd2;
  localparam logic [3:0] S_HD   = 4'd3;
  localparam logic [3:0] S_COR  = 4'd4;
  localparam logic [3:0] S_PX   = 4'd5;
  localparam logic [3:0] S_PY   = 4'd6;
  localparam logic [3:0] S_SM1  = 4'd7;
  localparam logic [3:0] S_SM2  = 4'd8;
  localparam logic [3:0] S_SDV  = 4'd9;
  localparam logic [3:0] S_TM1  = 4'd10;
  localparam logic [3:0] S_TM2  = 4'd11;
  localparam logic [3:0] S_TM3  = 4'd12;
  localparam logic [3:0] S_TDV  = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  logic [3:0] state_q, state_d, unit_next;
  logic       launched_q, launched_d;
  logic       out_valid_q, out_valid_d;
  op_e        unit_op;

  // operation and successor of each unit state
  always_comb begin
    unique case (state_q)
      S_ML:    begin unit_op = OP_ML;   unit_next = S_MR;   end
      S_MR:    begin unit_op = OP_MR;   unit_next = S_HD;   end
      S_HD:    begin unit_op = OP_HD;   unit_next = S_COR;  end
      S_COR:   begin unit_op = OP_COR;  unit_next = S_PX;   end
      S_PX:    begin unit_op = OP_PX;   unit_next = S_PY;   end
      S_PY:    begin unit_op = OP_PY;   unit_next = S_SM1;  end
      S_SM1:   begin unit_op = OP_SM1;  unit_next = S_SM2;  end
      S_SM2:   begin unit_op = OP_SM2;  unit_next = S_SDV;  end
      S_SDV:   begin unit_op = OP_SDV;  unit_next = S_TM1;  end
      S_TM1:   begin unit_op = OP_TM1;  unit_next = S_TM2;  end
      S_TM2:   begin unit_op = OP_TM2;  unit_next = S_TM3;  end
      S_TM3:   begin unit_op = OP_TM3;  unit_next = S_TDV;  end
      S_TDV:   begin unit_op = OP_TDV;  unit_next = S_DONE; end
      default: begin unit_op = OP_NONE; unit_next = S_IDLE; end
    endcase
  end

  // next state
  always_comb begin
    state_d     = state_q;
    launched_d  = launched_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o.op    = OP_NONE;
    cmd_o.start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op    = OP_LOAD;
          cmd_o.start = 1'b1;
          state_d     = stat_i.is_update ? S_ML : S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.op = OP_OUT;
        if (!out_valid_q || out_ready_i) begin
          cmd_o.start = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        cmd_o.op = unit_op;
        if (unit_op == OP_NONE) begin
          state_d    = S_IDLE;
          launched_d = 1'b0;
        end else if (!launched_q) begin
          cmd_o.start = 1'b1;
          launched_d  = 1'b1;
        end else if (stat_i.done) begin
          launched_d = 1'b0;
          state_d    = unit_next;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launched_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      launched_q  <= launched_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hw/rtl/differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry
// pose, speed and turn rate from timestamped wheel encoder positions
// ----------------------------------------------------------------------------
//  port group   direction  handshake              payload
//  cfg          in         cfg_we_i               cfg_idx_i, cfg_wdata_i
//  in           in         in_valid_i/in_ready_o  in_data_i (in_word_t)
//  out          out        out_valid_o/out_ready_i out_data_o (out_word_t)
//
// one word at a time; reset, first and repeated-stamp words go straight to the result
// an updating word runs ten products on the shift-add multiplier, the cordic
// and two quotients on the 128-bit divider
// rst_ni clears pose, encoder history, timestamp and both registers to zero
// a waiting result holds its word; the next word may be taken meanwhile
// ----------------------------------------------------------------------------
module differential_drive_odometry import ddo_pkg::*; #(
  parameter int CORDIC_STEPS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_word_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_word_t            out_data_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  ddo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath
  ddo_dp #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule

// File: hw/rtl/ddo_checker.sv
// ----------------------------------------------------------------------------
// ddo_checker
// port-level checks on the odometry block, bound to the top level
// ----------------------------------------------------------------------------
`include "differential_drive_odometry_assert.svh"

module ddo_checker import ddo_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_data_o
);

  logic in_take, out_stall, no_upd, zero_rates;

  // handshake shorthands
  assign in_take    = in_valid_i && in_ready_o;
  assign out_stall  = out_valid_o && !out_ready_i;
  assign no_upd     = out_valid_o && !out_data_o.updated;
  assign zero_rates = (out_data_o.speed == 32'sd0) && (out_data_o.turn_rate == 32'sd0);

  // a taken word blocks the input in the cycle after it is taken
  `DDO_ASSERT_NEXT(a_in_busy, clk_i, rst_ni, in_take, !in_ready_o)

  // no result appears in the cycle right after a word is taken while no result waits
  `DDO_ASSERT_NEXT(a_no_early_out, clk_i, rst_ni, in_take && !out_valid_o, !out_valid_o)

  // a word without a pose update reports zero rates
  `DDO_ASSERT_NOW(a_idle_rates, clk_i, rst_ni, no_upd, zero_rates)

  // a stalled result holds
  `DDO_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_data_o))

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
